[rtl/srt_pkg.sv]
package srt_pkg;

  localparam int unsigned ENTRIES     = 8;
  localparam int unsigned HANDLE_BITS = 16;

  localparam logic [31:0] MISS_APP = 32'h0000_FFFF;

  typedef enum logic [2:0] {
    OP_REGISTER   = 3'd0,
    OP_GET_HANDLE = 3'd1,
    OP_REMOVE     = 3'd2,
    OP_SET_ACTIVE = 3'd3,
    OP_SET_PASV   = 3'd4,
    OP_STATUS     = 3'd5,
    OP_APP_BY_HDL = 3'd6,
    OP_IS_LOCAL   = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    OUT_MATCHED = 2'd0,
    OUT_ADDED   = 2'd1,
    OUT_FULL    = 2'd2,
    OUT_NONE    = 2'd3
  } outcome_e;

  typedef logic [HANDLE_BITS-1:0] handle_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] node;
    logic [31:0] app;
    logic        passive;
    handle_t     handle;
  } slot_t;

  // request broadcast to every cell
  typedef struct packed {
    logic        accept;
    op_e         op;
    logic [31:0] node;
    logic [31:0] app;
    handle_t     handle;
  } key_t;

  // carried from cell to cell, oldest slot first
  typedef struct packed {
    logic        pair_hit;
    logic        pair_pas;
    handle_t     pair_hdl;
    logic        hdl_hit;
    logic        hdl_pas;
    handle_t     hdl_hdl;
    logic [31:0] hdl_app;
    logic        free_seen;
  } chain_t;

  function automatic handle_t handle_from_port(input logic [15:0] h);
    logic [31:0] ext;
    ext = {16'd0, h};
    return ext[HANDLE_BITS-1:0];
  endfunction

  function automatic logic [15:0] handle_to_port(input handle_t h);
    logic [31:0] ext;
    ext = 32'(h);
    return ext[15:0];
  endfunction

endpackage

[rtl/srt_cell.sv]
module srt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  srt_pkg::key_t   key_i,
  input  srt_pkg::chain_t chain_i,
  output srt_pkg::chain_t chain_o,
  input  srt_pkg::slot_t  nxt_i,
  output srt_pkg::slot_t  slot_o
);

  srt_pkg::slot_t   slot_q, slot_d;
  logic             valid_q;
  logic [31:0]      node_q, app_q;
  logic             passive_q;
  srt_pkg::handle_t handle_q;
  logic pair_m, hdl_m, first_pair;

  assign slot_q = {valid_q, node_q, app_q, passive_q, handle_q};

  assign pair_m = slot_q.valid && (slot_q.node == key_i.node) && (slot_q.app == key_i.app);
  assign hdl_m  = slot_q.valid && (slot_q.handle == key_i.handle);
  assign first_pair = pair_m && !chain_i.pair_hit;
  assign slot_o = slot_q;

  always_comb begin
    chain_o = chain_i;
    if (first_pair) begin
      chain_o.pair_hit = 1'b1;
      chain_o.pair_pas = slot_q.passive;
      chain_o.pair_hdl = slot_q.handle;
    end
    if (hdl_m && !chain_i.hdl_hit) begin
      chain_o.hdl_hit = 1'b1;
      chain_o.hdl_pas = slot_q.passive;
      chain_o.hdl_hdl = slot_q.handle;
      chain_o.hdl_app = slot_q.app;
    end
    if (!slot_q.valid) begin
      chain_o.free_seen = 1'b1;
    end
  end

  // entries are packed, so no match can lie past the first free slot
  always_comb begin
    slot_d = slot_q;
    if (key_i.accept) begin
      case (key_i.op)
        srt_pkg::OP_REGISTER: begin
          if (!chain_i.pair_hit && !slot_q.valid && !chain_i.free_seen) begin
            slot_d.valid   = 1'b1;
            slot_d.node    = key_i.node;
            slot_d.app     = key_i.app;
            slot_d.passive = 1'b0;
            slot_d.handle  = key_i.handle;
          end
        end
        srt_pkg::OP_REMOVE: begin
          if (chain_o.pair_hit) begin
            slot_d = nxt_i;
          end
        end
        srt_pkg::OP_SET_ACTIVE: begin
          if (first_pair) begin
            slot_d.passive = 1'b0;
          end
        end
        srt_pkg::OP_SET_PASV: begin
          if (first_pair) begin
            slot_d.passive = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= slot_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q    <= slot_d.node;
    app_q     <= slot_d.app;
    passive_q <= slot_d.passive;
    handle_q  <= slot_d.handle;
  end

endmodule

[rtl/service_registration_table.sv]
// Service registration table: eight slots kept in insertion order, matched on
// (node, app) or on process handle, oldest entry first. A request node id of
// zero stands for the local node register. One item is taken per cycle; each
// is resolved in the cycle it is accepted by a search through the row of slot
// cells, and its result sits in an output register. The input stalls only
// while that result is held by a stalled output. Removal shifts later slots
// up one place in the same cycle.
module service_registration_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [31:0] app_id_i,
  input  logic [31:0] node_id_i,
  input  logic [15:0] process_handle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  outcome_o,
  output logic        passive_o,
  output logic [15:0] handle_out_o,
  output logic [31:0] app_id_out_o
);

  logic [31:0] local_node_q;
  logic        out_valid_q, out_valid_d;
  logic        accept;

  srt_pkg::key_t   key;
  srt_pkg::chain_t chain [srt_pkg::ENTRIES+1];
  srt_pkg::slot_t  slots [srt_pkg::ENTRIES+1];
  srt_pkg::chain_t tail;

  srt_pkg::outcome_e outcome_d, outcome_q;
  logic              passive_d, passive_q;
  srt_pkg::handle_t  hdl_d, hdl_q;
  logic [31:0]       app_d, app_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign chain[0] = '0;
  assign slots[srt_pkg::ENTRIES] = '0;
  assign tail     = chain[srt_pkg::ENTRIES];

  always_comb begin
    key.accept   = accept;
    key.op       = srt_pkg::op_e'(op_i);
    key.node     = (node_id_i == 32'd0) ? local_node_q : node_id_i;
    key.app      = app_id_i;
    key.handle   = srt_pkg::handle_from_port(process_handle_i);
  end

  for (genvar g = 0; g < srt_pkg::ENTRIES; g++) begin : g_cell
    srt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key),
      .chain_i (chain[g]),
      .chain_o (chain[g+1]),
      .nxt_i   (slots[g+1]),
      .slot_o  (slots[g])
    );
  end

  always_comb begin
    outcome_d = srt_pkg::OUT_NONE;
    passive_d = 1'b0;
    hdl_d     = '0;
    app_d     = 32'd0;
    unique case (key.op)
      srt_pkg::OP_APP_BY_HDL: begin
        if (tail.hdl_hit) begin
          outcome_d = srt_pkg::OUT_MATCHED;
          passive_d = tail.hdl_pas;
          hdl_d     = tail.hdl_hdl;
          app_d     = tail.hdl_app;
        end else begin
          app_d = srt_pkg::MISS_APP;
        end
      end
      srt_pkg::OP_REGISTER: begin
        if (tail.pair_hit) begin
          outcome_d = srt_pkg::OUT_MATCHED;
          passive_d = tail.pair_pas;
          hdl_d     = tail.pair_hdl;
        end else if (tail.free_seen) begin
          outcome_d = srt_pkg::OUT_ADDED;
          hdl_d     = key.handle;
        end else begin
          outcome_d = srt_pkg::OUT_FULL;
        end
      end
      default: begin
        if (tail.pair_hit) begin
          outcome_d = srt_pkg::OUT_MATCHED;
          hdl_d     = tail.pair_hdl;
          if (key.op == srt_pkg::OP_SET_ACTIVE) begin
            passive_d = 1'b0;
          end else if (key.op == srt_pkg::OP_SET_PASV) begin
            passive_d = 1'b1;
          end else begin
            passive_d = tail.pair_pas;
          end
        end
      end
    endcase
  end

  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      local_node_q <= 32'd0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        local_node_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      outcome_q <= outcome_d;
      passive_q <= passive_d;
      hdl_q     <= hdl_d;
      app_q     <= app_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign outcome_o    = outcome_q;
  assign passive_o    = passive_q;
  assign handle_out_o = srt_pkg::handle_to_port(hdl_q);
  assign app_id_out_o = app_q;

endmodule
